// ===== rtl/rifp_pkg.sv =====
package rifp_pkg;

	localparam int TRIG_FRAC_BITS  = 14;
	localparam int SCALE_FRAC_BITS = 16;
	// cos(30 deg) in Q1.14, rounded to nearest
	localparam logic signed [15:0] COS30 = 16'sd14189;
	localparam int PX_SHIFT = 2 * TRIG_FRAC_BITS + 1 - 16;

	localparam int DIV_NW = 47;  // (avail << 32) + span/2
	localparam int DIV_DW = 35;  // span
	localparam int DIV_CW = 6;

	localparam logic signed [15:0] COS_RST    = 16'sd16384;
	localparam logic signed [15:0] SIN_RST    = 16'sd0;
	localparam logic [10:0]        MAP_W_RST  = 11'd10;
	localparam logic [10:0]        MAP_H_RST  = 11'd10;
	localparam logic [13:0]        WIN_W_RST  = 14'd1920;
	localparam logic [13:0]        WIN_H_RST  = 14'd1080;
	localparam logic [12:0]        MARGIN_RST = 13'd100;

	localparam logic KIND_FIT   = 1'b0;
	localparam logic KIND_POINT = 1'b1;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ACC   = 2'd1,
		CMD_FIT   = 2'd2,
		CMD_PROJ  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_COS    = 3'd0,
		REG_SIN    = 3'd1,
		REG_MAP_W  = 3'd2,
		REG_MAP_H  = 3'd3,
		REG_WIN_W  = 3'd4,
		REG_WIN_H  = 3'd5,
		REG_MARGIN = 3'd6
	} reg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLEAR,
		OP_M_CXC,
		OP_M_CYS,
		OP_M_CXS,
		OP_M_CYC,
		OP_ADD_RY,
		OP_M_ROT,
		OP_PX,
		OP_BOX,
		OP_M_SX,
		OP_M_SY,
		OP_TY,
		OP_SPAN,
		OP_M_AHW,
		OP_M_AWH,
		OP_CMP,
		OP_SCALE,
		OP_M_OX,
		OP_M_OY,
		OP_OFY,
		OP_OUT_PT,
		OP_OUT_FIT
	} op_t;

	typedef struct packed {
		logic div_busy;
		logic need_div;
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/rifp_div.sv =====
module rifp_div
	import rifp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              busy,
	output logic [DIV_NW-1:0] quot
);

	logic [DIV_NW-1:0] acc_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              ge;

	// restoring division, one quotient bit per cycle shifted into acc_q
	assign trial = {rem_q, acc_q[DIV_NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CW'(DIV_NW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= cnt_q != DIV_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			acc_q <= {acc_q[DIV_NW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = acc_q;

endmodule

// ===== rtl/rifp_ctrl.sv =====
module rifp_ctrl
	import rifp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic [1:0] cmd,
	input  dp_status_t status,
	output logic       s_tready,
	output op_t        op
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_CLR  = 9'b000000010,
		ST_ROT  = 9'b000000100,
		ST_BOX  = 9'b000001000,
		ST_PRJ  = 9'b000010000,
		ST_FIT  = 9'b000100000,
		ST_DIV  = 9'b001000000,
		ST_OFS  = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] step_q, step_d;
	logic [1:0] cmd_q;

	always_comb begin
		op       = OP_NONE;
		state_d  = state_q;
		step_d   = step_q + 1'b1;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				step_d   = '0;
				if (s_tvalid) begin
					op = OP_LOAD;
					case (cmd)
						CMD_CLEAR: state_d = ST_CLR;
						CMD_FIT:   state_d = ST_FIT;
						default:   state_d = ST_ROT;
					endcase
				end
			end
			ST_CLR: begin
				op      = OP_CLEAR;
				state_d = ST_IDLE;
			end
			ST_ROT: begin
				case (step_q)
					3'd0:    op = OP_M_CXC;
					3'd1:    op = OP_M_CYS;
					3'd2:    op = OP_M_CXS;
					3'd3:    op = OP_M_CYC;
					3'd4:    op = OP_ADD_RY;
					3'd5:    op = OP_M_ROT;
					default: op = OP_PX;
				endcase
				if (step_q == 3'd6) begin
					step_d  = '0;
					state_d = (cmd_q == CMD_ACC) ? ST_BOX : ST_PRJ;
				end
			end
			ST_BOX: begin
				op      = OP_BOX;
				state_d = ST_IDLE;
			end
			ST_PRJ: begin
				case (step_q)
					3'd0:    op = OP_M_SX;
					3'd1:    op = OP_M_SY;
					default: op = OP_TY;
				endcase
				if (step_q == 3'd2)
					state_d = ST_OUT;
			end
			ST_FIT: begin
				case (step_q)
					3'd0:    op = OP_SPAN;
					3'd1:    op = OP_M_AHW;
					3'd2:    op = OP_M_AWH;
					default: op = OP_CMP;
				endcase
				if (step_q == 3'd3) begin
					step_d  = '0;
					state_d = status.need_div ? ST_DIV : ST_OFS;
				end
			end
			ST_DIV: begin
				step_d = '0;
				if (!status.div_busy) begin
					op      = OP_SCALE;
					state_d = ST_OFS;
				end
			end
			ST_OFS: begin
				case (step_q)
					3'd0:    op = OP_M_OX;
					3'd1:    op = OP_M_OY;
					default: op = OP_OFY;
				endcase
				if (step_q == 3'd2)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					op      = (cmd_q == CMD_FIT) ? OP_OUT_FIT : OP_OUT_PT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			cmd_q   <= CMD_CLEAR;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (s_tready && s_tvalid)
				cmd_q <= cmd;
		end
	end

endmodule

// ===== rtl/rifp_dp.sv =====
module rifp_dp
	import rifp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  op_t                op,
	input  logic               cfg_wen,
	input  logic [2:0]         cfg_idx,
	input  logic [15:0]        cfg_wdata,
	input  logic [9:0]         point_x,
	input  logic [9:0]         point_y,
	input  logic signed [15:0] point_z,
	input  logic               m_tready,
	output dp_status_t         status,
	output logic               m_tvalid,
	output logic               result_kind,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	output logic signed [15:0] height_out,
	output logic [31:0]        scale_out
);

	function automatic logic signed [39:0] rshr_px(input logic signed [69:0] v);
		logic [69:0] m;
		logic [69:0] r;
		m = v[69] ? 70'(-v) : 70'(v);
		r = (m + (70'd1 << (PX_SHIFT - 1))) >> PX_SHIFT;
		return v[69] ? -40'(r) : 40'(r);
	endfunction

	function automatic logic signed [35:0] rshr16(input logic signed [51:0] v);
		logic [51:0] m;
		logic [51:0] r;
		m = v[51] ? 52'(-v) : 52'(v);
		r = (m + 52'd32768) >> 16;
		return v[51] ? -36'(r) : 36'(r);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sh07FFFFFFF)
			return 32'sh7FFFFFFF;
		if (v < -36'sh080000000)
			return 32'sh80000000;
		return 32'(v);
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
		if (v > 52'sh07FFFFFFFFFFF)
			return 48'sh7FFFFFFFFFFF;
		if (v < -52'sh0800000000000)
			return 48'sh800000000000;
		return 48'(v);
	endfunction

	function automatic logic signed [34:0] abs35(input logic signed [40:0] v);
		return v[40] ? 35'(-v) : 35'(v);
	endfunction

	// configuration
	logic signed [15:0] cos_q, sin_q;
	logic [10:0]        mw_q, mh_q;
	logic [13:0]        ww_q, wh_q;
	logic [12:0]        mg_q;

	// working registers
	logic signed [12:0] cx2_q, cy2_q;
	logic signed [15:0] z_q;
	logic signed [30:0] rx_q, ry_q;
	logic signed [39:0] px_q, py_q;
	logic signed [69:0] p_q;
	logic               msgn_q;
	logic signed [51:0] tx_q, ty_q;
	logic signed [40:0] w_q, h_q;
	logic [47:0]        cmpa_q;

	// persistent state
	logic signed [39:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic               bvalid_q;
	logic [31:0]        scale_q;
	logic signed [47:0] offx_q, offy_q;

	logic               out_valid_q;

	logic signed [34:0] mul_a, mul_b;
	logic [13:0]        aw, ah;
	logic signed [40:0] sum_x, sum_y;
	logic signed [51:0] q16, q17, mq16, mq17;
	logic               w_pos, h_pos, use_h;
	logic               div_start, div_busy;
	logic [DIV_NW-1:0]  div_num, div_quot;
	logic [DIV_DW-1:0]  div_den;

	assign aw    = (ww_q > 14'(mg_q)) ? ww_q - 14'(mg_q) : '0;
	assign ah    = (wh_q > 14'(mg_q)) ? wh_q - 14'(mg_q) : '0;
	assign sum_x = 41'(min_x_q) + 41'(max_x_q);
	assign sum_y = 41'(min_y_q) + 41'(max_y_q);
	assign w_pos = !w_q[40] && (w_q != '0);
	assign h_pos = !h_q[40] && (h_q != '0);
	// ties take the width ratio
	assign use_h = (w_pos && h_pos) ? (cmpa_q < p_q[47:0]) : h_pos;

	// magnitude products rounded back to Q.16
	assign q16  = 52'((p_q + (70'sd1 <<< (SCALE_FRAC_BITS - 1))) >>> SCALE_FRAC_BITS);
	assign q17  = 52'((p_q + (70'sd1 <<< SCALE_FRAC_BITS)) >>> (SCALE_FRAC_BITS + 1));
	assign mq16 = msgn_q ? -q16 : q16;
	assign mq17 = msgn_q ? -q17 : q17;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op)
			OP_M_CXC: begin mul_a = 35'(cx2_q); mul_b = 35'(cos_q); end
			OP_M_CYS: begin mul_a = 35'(cy2_q); mul_b = 35'(sin_q); end
			OP_M_CXS: begin mul_a = 35'(cx2_q); mul_b = 35'(sin_q); end
			OP_M_CYC: begin mul_a = 35'(cy2_q); mul_b = 35'(cos_q); end
			OP_M_ROT: begin mul_a = 35'(rx_q) - 35'(ry_q); mul_b = 35'(COS30); end
			OP_M_SX:  begin mul_a = abs35(41'(px_q)); mul_b = 35'(scale_q); end
			OP_M_SY:  begin mul_a = abs35(41'(py_q)); mul_b = 35'(scale_q); end
			OP_M_AHW: begin mul_a = 35'(w_q); mul_b = 35'(ah); end
			OP_M_AWH: begin mul_a = 35'(h_q); mul_b = 35'(aw); end
			OP_M_OX:  begin mul_a = abs35(sum_x); mul_b = 35'(scale_q); end
			OP_M_OY:  begin mul_a = abs35(sum_y); mul_b = 35'(scale_q); end
			default: ;
		endcase
	end

	assign div_start = (op == OP_CMP) && (w_pos || h_pos);
	assign div_den   = use_h ? DIV_DW'(h_q) : DIV_DW'(w_q);
	assign div_num   = ((use_h ? DIV_NW'(ah) : DIV_NW'(aw)) << 32)
	                 + DIV_NW'(div_den >> 1);

	rifp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= COS_RST;
			sin_q <= SIN_RST;
			mw_q  <= MAP_W_RST;
			mh_q  <= MAP_H_RST;
			ww_q  <= WIN_W_RST;
			wh_q  <= WIN_H_RST;
			mg_q  <= MARGIN_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_COS:    cos_q <= cfg_wdata;
				REG_SIN:    sin_q <= cfg_wdata;
				REG_MAP_W:  mw_q  <= cfg_wdata[10:0];
				REG_MAP_H:  mh_q  <= cfg_wdata[10:0];
				REG_WIN_W:  ww_q  <= cfg_wdata[13:0];
				REG_WIN_H:  wh_q  <= cfg_wdata[13:0];
				REG_MARGIN: mg_q  <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q  <= '0;
			max_x_q  <= '0;
			min_y_q  <= '0;
			max_y_q  <= '0;
			bvalid_q <= 1'b0;
			scale_q  <= '0;
			offx_q   <= '0;
			offy_q   <= '0;
		end else begin
			case (op)
				OP_CLEAR: begin
					min_x_q  <= '0;
					max_x_q  <= '0;
					min_y_q  <= '0;
					max_y_q  <= '0;
					bvalid_q <= 1'b0;
				end
				OP_BOX: begin
					bvalid_q <= 1'b1;
					if (!bvalid_q || px_q < min_x_q) min_x_q <= px_q;
					if (!bvalid_q || px_q > max_x_q) max_x_q <= px_q;
					if (!bvalid_q || py_q < min_y_q) min_y_q <= py_q;
					if (!bvalid_q || py_q > max_y_q) max_y_q <= py_q;
				end
				OP_CMP: begin
					if (!(w_pos || h_pos))
						scale_q <= 32'(aw) << SCALE_FRAC_BITS;
				end
				OP_SCALE: begin
					scale_q <= (div_quot[DIV_NW-1:32] != '0) ? 32'hFFFFFFFF
					                                         : div_quot[31:0];
				end
				OP_M_OY: offx_q <= sat48($signed(52'(ww_q) << 15) - mq17);
				OP_OFY:  offy_q <= sat48($signed(52'(wh_q) << 15) - mq17);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		p_q <= 70'(mul_a) * 70'(mul_b);
		case (op)
			OP_LOAD: begin
				cx2_q <= $signed({2'b00, point_x, 1'b0}) - ($signed({2'b00, mw_q}) - 13'sd1);
				cy2_q <= $signed({2'b00, point_y, 1'b0}) - ($signed({2'b00, mh_q}) - 13'sd1);
				z_q   <= point_z;
			end
			OP_M_CYS:  rx_q <= 31'(p_q);
			OP_M_CXS:  rx_q <= rx_q - 31'(p_q);
			OP_M_CYC:  ry_q <= 31'(p_q);
			OP_ADD_RY: ry_q <= ry_q + 31'(p_q);
			OP_M_ROT:  py_q <= 40'(rx_q) + 40'(ry_q) - (40'(z_q) <<< 16);
			OP_PX:     px_q <= rshr_px(p_q);
			OP_M_SX:   msgn_q <= px_q[39];
			OP_M_SY: begin
				tx_q   <= mq16 + 52'(offx_q);
				msgn_q <= py_q[39];
			end
			OP_TY:     ty_q <= mq16 + 52'(offy_q);
			OP_SPAN: begin
				w_q <= 41'(max_x_q) - 41'(min_x_q);
				h_q <= 41'(max_y_q) - 41'(min_y_q);
			end
			OP_M_AWH:  cmpa_q <= p_q[47:0];
			OP_M_OX:   msgn_q <= sum_x[40];
			OP_M_OY:   msgn_q <= sum_y[40];
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (op == OP_OUT_PT || op == OP_OUT_FIT)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (op == OP_OUT_PT) begin
			result_kind <= KIND_POINT;
			screen_x    <= sat32(rshr16(tx_q));
			screen_y    <= sat32(rshr16(ty_q));
			height_out  <= z_q;
			scale_out   <= '0;
		end else if (op == OP_OUT_FIT) begin
			result_kind <= KIND_FIT;
			screen_x    <= '0;
			screen_y    <= '0;
			height_out  <= '0;
			scale_out   <= scale_q;
		end
	end

	assign m_tvalid        = out_valid_q;
	assign status.div_busy = div_busy;
	assign status.need_div = w_pos || h_pos;
	assign status.out_free = !out_valid_q || m_tready;

endmodule

// ===== rtl/rotate_isometric_fit_project.sv =====
// Rotated isometric projection with fit-to-window.
//
// Input stream (s_*): one command per transaction, cmd in s_tuser.
//   clear empties the bounding box, accumulate widens it with one projected
//   point, fit derives scale and offsets and returns a fit result, project
//   returns one screen point. Clear and accumulate return nothing.
// Output stream (m_*): result_kind in m_tuser; fit results carry the Q16.16
//   scale, projected points carry screen x/y and the passed-through height.
// Commands are handled one at a time on a single shared 35x35 multiplier;
//   the bit-serial divider dominates a fit, and a fit with both spans zero
//   skips it.
// A finished result sits in the output register; the next command is
//   accepted while it waits. If the receiver stalls with a result pending, a
//   following fit or project stops just before its own result until taken.
// Configuration writes (cfg_*) take effect at once; write only when idle.
// Reset restores the register defaults and clears box, scale and offsets.
module rotate_isometric_fit_project
	import rifp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wen,
	input  logic [2:0]    cfg_idx,
	input  logic [15:0]   cfg_wdata,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [39:0]   s_tdata,   // point_x[9:0], point_y[19:10], point_z[35:20]
	input  logic [1:0]    s_tuser,   // cmd[1:0]
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [111:0]  m_tdata,   // screen_x[31:0], screen_y[63:32],
	                                 // height_out[79:64], scale_out[111:80]
	output logic [0:0]    m_tuser    // result_kind[0]
);

	op_t                op;
	dp_status_t         status;
	logic               result_kind;
	logic signed [31:0] screen_x, screen_y;
	logic signed [15:0] height_out;
	logic [31:0]        scale_out;

	rifp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.cmd      (s_tuser),
		.status   (status),
		.s_tready (s_tready),
		.op       (op)
	);

	rifp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.cfg_wen     (cfg_wen),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.point_x     (s_tdata[9:0]),
		.point_y     (s_tdata[19:10]),
		.point_z     (s_tdata[35:20]),
		.m_tready    (m_tready),
		.status      (status),
		.m_tvalid    (m_tvalid),
		.result_kind (result_kind),
		.screen_x    (screen_x),
		.screen_y    (screen_y),
		.height_out  (height_out),
		.scale_out   (scale_out)
	);

	assign m_tdata = {scale_out, height_out, screen_y, screen_x};
	assign m_tuser = result_kind;

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command accepted while previous one in flight");

	a_div_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_busy |-> !s_tready)
		else $error("input ready during division");

	a_fit_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == KIND_FIT) |-> (m_tdata[79:0] == '0))
		else $error("fit result with nonzero point fields");
`endif

endmodule

// ===== dv/tb.sv =====
module tb;
	import rifp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        kind;
		logic [31:0] sx;
		logic [31:0] sy;
		logic [15:0] hgt;
		logic [31:0] scl;
	} screen_res_t;

	class screen_scoreboard;
		logic signed [15:0] cos_r, sin_r;
		logic [10:0] map_w, map_h;
		logic [13:0] win_w, win_h;
		logic [12:0] margin;
		longint min_x, max_x, min_y, max_y, off_x, off_y;
		bit box_valid;
		logic [31:0] scale;
		screen_res_t pending[$];
		int errors;

		function void reset_state();
			cos_r = COS_RST; sin_r = SIN_RST;
			map_w = MAP_W_RST; map_h = MAP_H_RST;
			win_w = WIN_W_RST; win_h = WIN_H_RST; margin = MARGIN_RST;
			min_x = 0; max_x = 0; min_y = 0; max_y = 0;
			off_x = 0; off_y = 0; box_valid = 0; scale = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [15:0] v);
			case (idx)
				REG_COS:    cos_r = v;
				REG_SIN:    sin_r = v;
				REG_MAP_W:  map_w = v[10:0];
				REG_MAP_H:  map_h = v[10:0];
				REG_WIN_W:  win_w = v[13:0];
				REG_WIN_H:  win_h = v[13:0];
				REG_MARGIN: margin = v[12:0];
				default: ;
			endcase
		endfunction

		// divide by 2^s, half away from zero
		function longint rnd_shift(longint v, int s);
			longint m;
			if (s == 0) return v;
			m = (v < 0) ? -v : v;
			m = (m + (longint'(1) <<< (s - 1))) >>> s;
			return (v < 0) ? -m : m;
		endfunction

		// sign(a) * round(|a| * b / 2^s)
		function longint scaled(longint a, logic [31:0] b, int s);
			logic [127:0] p, q;
			logic [63:0] m;
			m = (a < 0) ? -a : a;
			p = {64'd0, m} * {96'd0, b};
			q = (p >> s) + p[s-1];
			return (a < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
		endfunction

		function longint clip(longint v, int w);
			longint hi;
			hi = (longint'(1) <<< (w - 1)) - 1;
			if (v > hi) return hi;
			if (v < -hi - 1) return -hi - 1;
			return v;
		endfunction

		function void iso_point(logic [9:0] x, logic [9:0] y, logic signed [15:0] z,
				output longint px, output longint py);
			longint cx2, cy2, rx2, ry2;
			cx2 = 2 * longint'(x) - (longint'(map_w) - 1);
			cy2 = 2 * longint'(y) - (longint'(map_h) - 1);
			rx2 = cx2 * longint'(cos_r) - cy2 * longint'(sin_r);
			ry2 = cx2 * longint'(sin_r) + cy2 * longint'(cos_r);
			px = rnd_shift((rx2 - ry2) * longint'(COS30), PX_SHIFT);
			py = (rx2 + ry2) - longint'(z) * 65536;
		endfunction

		function longint usable(logic [13:0] win);
			return (win > margin) ? longint'(win) - longint'(margin) : 0;
		endfunction

		function logic [31:0] fit_ratio(longint av, longint span);
			longint q;
			q = ((av <<< 32) + span / 2) / span;
			return (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
		endfunction

		function void fit_box();
			longint w, h, aw, ah, q;
			bit use_h;
			w = max_x - min_x; h = max_y - min_y;
			aw = usable(win_w); ah = usable(win_h);
			use_h = (w > 0 && h > 0) ? (ah * w < aw * h) : (h > 0);
			if (use_h) scale = fit_ratio(ah, h);
			else if (w > 0) scale = fit_ratio(aw, w);
			else begin
				q = aw <<< 16;
				scale = (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
			end
			off_x = clip(longint'(win_w) * 32768 - scaled(min_x + max_x, scale, 17), 48);
			off_y = clip(longint'(win_h) * 32768 - scaled(min_y + max_y, scale, 17), 48);
		endfunction

		function void note_cmd(cmd_t c, logic [9:0] x, logic [9:0] y, logic signed [15:0] z);
			longint px, py;
			screen_res_t r;
			case (c)
				CMD_CLEAR: begin
					min_x = 0; max_x = 0; min_y = 0; max_y = 0; box_valid = 0;
				end
				CMD_FIT: begin
					fit_box();
					r.kind = KIND_FIT; r.sx = 0; r.sy = 0; r.hgt = 0; r.scl = scale;
					pending.push_back(r);
				end
				CMD_ACC: begin
					iso_point(x, y, z, px, py);
					if (!box_valid) begin
						min_x = px; max_x = px; min_y = py; max_y = py; box_valid = 1;
					end else begin
						if (px < min_x) min_x = px;
						if (px > max_x) max_x = px;
						if (py < min_y) min_y = py;
						if (py > max_y) max_y = py;
					end
				end
				default: begin
					iso_point(x, y, z, px, py);
					r.kind = KIND_POINT;
					r.sx = 32'(clip(rnd_shift(scaled(px, scale, 16) + off_x, 16), 32));
					r.sy = 32'(clip(rnd_shift(scaled(py, scale, 16) + off_y, 16), 32));
					r.hgt = z; r.scl = 0;
					pending.push_back(r);
				end
			endcase
		endfunction

		function void check_result(screen_res_t got);
			screen_res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result kind=%0d x=%0d y=%0d", $realtime, got.kind,
					$signed(got.sx), $signed(got.sy));
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.kind !== e.kind) begin
				$display("%0t: result_kind exp %0d got %0d", $realtime, e.kind, got.kind);
				errors++;
			end
			if (got.sx !== e.sx) begin
				$display("%0t: screen_x exp %0d got %0d", $realtime, $signed(e.sx), $signed(got.sx));
				errors++;
			end
			if (got.sy !== e.sy) begin
				$display("%0t: screen_y exp %0d got %0d", $realtime, $signed(e.sy), $signed(got.sy));
				errors++;
			end
			if (got.hgt !== e.hgt) begin
				$display("%0t: height_out exp %0d got %0d", $realtime, $signed(e.hgt),
					$signed(got.hgt));
				errors++;
			end
			if (got.scl !== e.scl) begin
				$display("%0t: scale_out exp %h got %h", $realtime, e.scl, got.scl);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, cfg_wen, s_tvalid, s_tready, m_tvalid, m_tready;
	logic [2:0] cfg_idx;
	logic [15:0] cfg_wdata;
	logic [39:0] s_tdata;
	logic [1:0] s_tuser;
	logic [111:0] m_tdata;
	logic [0:0] m_tuser;

	screen_scoreboard sb;
	int tx_idle, rx_idle, n_sent;
	longint cycles = 0;

	rotate_isometric_fit_project DUT (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) m_tready <= ($urandom_range(99) >= rx_idle);

	always @(posedge clk) begin
		screen_res_t got;
		if (arst_n && s_tvalid && s_tready)
			sb.note_cmd(cmd_t'(s_tuser), s_tdata[9:0], s_tdata[19:10], s_tdata[35:20]);
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser[0]; got.sx = m_tdata[31:0]; got.sy = m_tdata[63:32];
			got.hgt = m_tdata[79:64]; got.scl = m_tdata[111:80];
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 1500000) begin
			$display("rotate_isometric_fit_project regression: fail");
			$finish;
		end
	end

	task automatic send(cmd_t c, logic [9:0] x, logic [9:0] y, logic [15:0] z);
		if ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= c;
		s_tdata <= {4'd0, z, y, x};
		do @(posedge clk); while (!s_tready);
		n_sent++;
	endtask

	// fit takes the longest; give the datapath time to settle before writes
	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [15:0] v);
		cfg_wen <= 1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic cfg_done();
		cfg_wen <= 0;
		@(posedge clk);
	endtask

	function automatic int pick(int lo, int hi);
		int r;
		r = $urandom_range(99);
		if (r < 12) return lo;
		if (r < 24) return hi;
		return $urandom_range(hi - lo) + lo;
	endfunction

	task automatic random_config();
		int ww, wh;
		drain();
		ww = pick(1, 8192);
		wh = pick(1, 8192);
		cfg_write(REG_COS, 16'(pick(-16384, 16384)));
		cfg_write(REG_SIN, 16'(pick(-16384, 16384)));
		cfg_write(REG_MAP_W, 16'(pick(1, 1024)));
		cfg_write(REG_MAP_H, 16'(pick(1, 1024)));
		cfg_write(REG_WIN_W, 16'(ww));
		cfg_write(REG_WIN_H, 16'(wh));
		// margin mostly below both window sizes, sometimes not
		if ($urandom_range(9) == 0) cfg_write(REG_MARGIN, 16'(pick(0, 8191)));
		else cfg_write(REG_MARGIN, 16'($urandom_range(((ww < wh) ? ww : wh) - 1)));
		cfg_done();
	endtask

	function automatic logic [9:0] rnd_coord();
		return 10'(pick(0, 1023));
	endfunction

	function automatic logic [15:0] rnd_height();
		int r;
		r = $urandom_range(99);
		if (r < 10) return 16'h8000;
		if (r < 20) return 16'h7FFF;
		if (r < 45) return 16'($urandom_range(16'hFFFF));
		return 16'($signed($urandom_range(100)) - 50);
	endfunction

	task automatic random_phase(int n_items);
		int stop, k;
		stop = n_sent + n_items;
		while (n_sent < stop) begin
			if ($urandom_range(99) < 15) random_config();
			send(CMD_CLEAR, rnd_coord(), rnd_coord(), rnd_height());
			k = $urandom_range(1, 8);
			repeat (k) send(CMD_ACC, rnd_coord(), rnd_coord(), rnd_height());
			send(CMD_FIT, rnd_coord(), rnd_coord(), rnd_height());
			k = $urandom_range(1, 8);
			repeat (k) send(CMD_PROJ, rnd_coord(), rnd_coord(), rnd_height());
			// noise: arbitrary command mix
			if ($urandom_range(9) < 3)
				repeat ($urandom_range(1, 6))
					send(cmd_t'($urandom_range(3)), rnd_coord(), rnd_coord(), rnd_height());
		end
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		sb.errors = 0;
		n_sent = 0;
		tx_idle = 22;
		rx_idle = 62;
		arst_n = 0;
		cfg_wen = 0; cfg_idx = REG_COS; cfg_wdata = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = CMD_CLEAR;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// project before any fit, fit on an empty box
		send(CMD_PROJ, 10'd3, 10'd7, 16'd5);
		send(CMD_FIT, 0, 0, 0);
		send(CMD_ACC, 10'd0, 10'd0, 16'h8000);
		send(CMD_ACC, 10'd1023, 10'd1023, 16'h7FFF);
		send(CMD_ACC, 10'd1023, 10'd0, 16'h0000);
		send(CMD_FIT, 0, 0, 0);
		send(CMD_PROJ, 10'd0, 10'd1023, 16'h8000);
		send(CMD_PROJ, 10'd1023, 10'd0, 16'h7FFF);
		send(CMD_CLEAR, 10'h3FF, 10'h3FF, 16'hFFFF);
		send(CMD_FIT, 0, 0, 0);
		// margin above the window width: no usable width
		drain();
		cfg_write(REG_WIN_W, 16'd50);
		cfg_write(REG_WIN_H, 16'd8192);
		cfg_write(REG_MARGIN, 16'd8191);
		cfg_done();
		send(CMD_ACC, 10'd5, 10'd2, 16'd1);
		send(CMD_ACC, 10'd600, 10'd900, 16'd3);
		send(CMD_FIT, 0, 0, 0);
		send(CMD_PROJ, 10'd600, 10'd900, 16'd3);
		// tiny span: scale saturates, then projections saturate
		drain();
		cfg_write(REG_COS, 16'd1);
		cfg_write(REG_SIN, 16'd0);
		cfg_write(REG_MAP_W, 16'd1024);
		cfg_write(REG_MAP_H, 16'd1);
		cfg_write(REG_WIN_W, 16'd8192);
		cfg_write(REG_MARGIN, 16'd0);
		cfg_done();
		send(CMD_CLEAR, 0, 0, 0);
		send(CMD_ACC, 10'd0, 10'd0, 16'd0);
		send(CMD_ACC, 10'd1, 10'd0, 16'd0);
		send(CMD_FIT, 0, 0, 0);
		drain();
		cfg_write(REG_COS, 16'hC000);
		cfg_write(REG_SIN, 16'd16384);
		cfg_done();
		send(CMD_PROJ, 10'd1023, 10'd0, 16'h7FFF);
		send(CMD_PROJ, 10'd0, 10'd1023, 16'h8000);

		random_phase(600);
		drain();
		tx_idle = 62;
		rx_idle = 22;
		random_phase(600);
		drain();
		tx_idle = 0;
		rx_idle = 0;
		random_phase(600);
		drain();

		if (sb.errors == 0)
			$display("rotate_isometric_fit_project regression: pass");
		else
			$display("rotate_isometric_fit_project regression: fail");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/rifp_pkg.sv
rtl/rifp_div.sv
rtl/rifp_ctrl.sv
rtl/rifp_dp.sv
rtl/rotate_isometric_fit_project.sv
dv/tb.sv
